>>> rtl/ips_pkg.sv
// ----------------------------------------------------------------------------
// IPS patch stream parser package
// Shared types and constants for the parser and its output buffer.
// ----------------------------------------------------------------------------
package ips_pkg;

  typedef enum logic [3:0] {
    PH_HEADER,
    PH_HDR_BAD,
    PH_OFFSET,
    PH_SIZE,
    PH_DATA,
    PH_RUN_LEN,
    PH_RUN_VAL,
    PH_DONE,
    PH_ERROR
  } phase_e;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_FILL  = 2'd1,
    KIND_END   = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_of_patch;
  } in_t;

  typedef struct packed {
    kind_e       kind;
    logic [23:0] address;
    logic [15:0] fill_length;
    logic [7:0]  value;
  } out_t;

  localparam logic [23:0] EofMark     = 24'h454F46;
  localparam logic [2:0]  HdrLen      = 3'd5;
  localparam logic [2:0]  OffsetLen   = 3'd3;
  localparam logic [2:0]  SizeLen     = 3'd2;
  localparam logic [2:0]  RunLenLen   = 3'd2;

  function automatic logic [7:0] hdr_byte(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = 8'h50;
      3'd1:    r = 8'h41;
      3'd2:    r = 8'h54;
      3'd3:    r = 8'h43;
      3'd4:    r = 8'h48;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/ips_parse_core.sv
// ----------------------------------------------------------------------------
// IPS record parser
// Per-byte phase update; produces at most one result for each accepted byte.
// ----------------------------------------------------------------------------
module ips_parse_core import ips_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_fire_i,
  input  in_t  in_data_i,
  output logic res_valid_o,
  output out_t res_data_o
);

  phase_e      phase_q, phase_d, cur_phase;
  logic [2:0]  cnt_q, cnt_d, cur_cnt, cnt_inc;
  logic [23:0] roff_q, roff_d, cur_roff, roff_shift;
  logic [23:0] waddr_q, waddr_d, cur_waddr;
  logic [15:0] rem_q, rem_d, cur_rem, rem_shift, rem_dec;
  logic [15:0] rlen_q, rlen_d, cur_rlen;
  logic [7:0]  b;
  logic        hdr_bad;

  assign b = in_data_i.in_byte;

  always_comb begin
    if (in_data_i.start_of_patch) begin
      cur_phase = PH_HEADER;
      cur_cnt   = '0;
      cur_roff  = '0;
      cur_waddr = '0;
      cur_rem   = '0;
      cur_rlen  = '0;
    end else begin
      cur_phase = phase_q;
      cur_cnt   = cnt_q;
      cur_roff  = roff_q;
      cur_waddr = waddr_q;
      cur_rem   = rem_q;
      cur_rlen  = rlen_q;
    end
  end

  assign cnt_inc    = cur_cnt + 3'd1;
  assign roff_shift = {cur_roff[15:0], b};
  assign rem_shift  = {cur_rem[7:0], b};
  assign rem_dec    = cur_rem - 16'd1;
  assign hdr_bad    = (b != hdr_byte(cur_cnt)) || (cur_phase == PH_HDR_BAD);

  // next state
  always_comb begin
    phase_d = cur_phase;
    cnt_d   = cur_cnt;
    roff_d  = cur_roff;
    waddr_d = cur_waddr;
    rem_d   = cur_rem;
    rlen_d  = cur_rlen;
    case (cur_phase)
      PH_HEADER, PH_HDR_BAD: begin
        if (cnt_inc >= HdrLen) begin
          cnt_d   = '0;
          phase_d = hdr_bad ? PH_ERROR : PH_OFFSET;
        end else begin
          cnt_d   = cnt_inc;
          phase_d = hdr_bad ? PH_HDR_BAD : PH_HEADER;
        end
      end
      PH_OFFSET: begin
        roff_d = roff_shift;
        if (cnt_inc >= OffsetLen) begin
          cnt_d = '0;
          if (roff_shift == EofMark) begin
            phase_d = PH_DONE;
          end else begin
            rem_d   = '0;
            phase_d = PH_SIZE;
          end
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PH_SIZE: begin
        rem_d = rem_shift;
        if (cnt_inc >= SizeLen) begin
          cnt_d = '0;
          if (rem_shift == '0) begin
            rlen_d  = '0;
            phase_d = PH_RUN_LEN;
          end else begin
            waddr_d = cur_roff;
            phase_d = PH_DATA;
          end
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PH_DATA: begin
        waddr_d = cur_waddr + 24'd1;
        rem_d   = rem_dec;
        if (rem_dec == '0) begin
          roff_d  = '0;
          phase_d = PH_OFFSET;
        end
      end
      PH_RUN_LEN: begin
        rlen_d = {cur_rlen[7:0], b};
        if (cnt_inc >= RunLenLen) begin
          cnt_d   = '0;
          phase_d = PH_RUN_VAL;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PH_RUN_VAL: begin
        roff_d  = '0;
        phase_d = PH_OFFSET;
      end
      default: ;
    endcase
  end

  // result
  always_comb begin
    res_valid_o = 1'b0;
    res_data_o  = '{kind: KIND_WRITE, address: '0, fill_length: '0, value: '0};
    case (cur_phase)
      PH_HEADER, PH_HDR_BAD: begin
        if (cnt_inc >= HdrLen && hdr_bad) begin
          res_valid_o     = 1'b1;
          res_data_o.kind = KIND_ERROR;
        end
      end
      PH_OFFSET: begin
        if (cnt_inc >= OffsetLen && roff_shift == EofMark) begin
          res_valid_o     = 1'b1;
          res_data_o.kind = KIND_END;
        end
      end
      PH_DATA: begin
        res_valid_o        = 1'b1;
        res_data_o.kind    = KIND_WRITE;
        res_data_o.address = cur_waddr;
        res_data_o.value   = b;
      end
      PH_RUN_VAL: begin
        res_valid_o            = 1'b1;
        res_data_o.kind        = KIND_FILL;
        res_data_o.address     = cur_roff;
        res_data_o.fill_length = cur_rlen;
        res_data_o.value       = b;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      cnt_q   <= '0;
      roff_q  <= '0;
      waddr_q <= '0;
      rem_q   <= '0;
      rlen_q  <= '0;
    end else if (in_fire_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      roff_q  <= roff_d;
      waddr_q <= waddr_d;
      rem_q   <= rem_d;
      rlen_q  <= rlen_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HEADER || phase_q == PH_HDR_BAD) |-> cnt_q < HdrLen)
    else $error("header byte count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> rem_q != '0)
    else $error("data phase with nothing remaining");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire_i && !in_data_i.start_of_patch &&
     (phase_q == PH_DONE || phase_q == PH_ERROR)) |=> $stable(phase_q))
    else $error("terminal phase left without a restart");

endmodule

>>> rtl/ips_out_skid.sv
// ----------------------------------------------------------------------------
// IPS result buffer
// Output register with a skid stage so the input side is stalled only from
// a registered signal.
// ----------------------------------------------------------------------------
module ips_out_skid import ips_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  out_t push_data_i,
  output logic full_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  logic out_valid_q, skid_valid_q;
  out_t out_data_q, skid_data_q;
  logic out_fire;

  assign out_fire    = out_valid_q && !out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (out_valid_q && !out_fire) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_data_q <= skid_data_q;
      end
    end else if (push_i) begin
      if (out_valid_q && !out_fire) begin
        skid_data_q <= push_data_i;
      end else begin
        out_data_q <= push_data_i;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds data while output register is empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i && push_i))
    else $error("skid filled without a stalled output");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !out_stall_i) |=> !skid_valid_q)
    else $error("skid not drained after output transfer");

endmodule

>>> rtl/ips_patch_stream_parser.sv
// ----------------------------------------------------------------------------
// IPS patch stream parser
// Parses an IPS patch byte stream into write, fill, end and error results.
// ----------------------------------------------------------------------------
// One patch byte is taken per cycle unless in_stall_o is high, and it is
// parsed in the cycle it is accepted. Its result, if any, is registered in a
// two-entry output buffer (output register plus skid stage) that decouples
// the sides; input is stalled only once both entries hold untaken results.
// A byte flagged start_of_patch restarts the parser and is the first header
// byte. After the end marker or a bad header, bytes are dropped until the
// next restart.
module ips_patch_stream_parser import ips_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  logic in_fire;
  logic res_valid;
  out_t res_data;
  logic buf_full;

  assign in_stall_o = buf_full;
  assign in_fire    = in_valid_i && !buf_full;

  ips_parse_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .in_data_i  (in_data_i),
    .res_valid_o(res_valid),
    .res_data_o (res_data)
  );

  ips_out_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_fire && res_valid),
    .push_data_i (res_data),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPS patch stream parser testbench
// Drives byte streams into the parser: a short table of hand-made patches
// first, then random patches that are mostly well formed, with bad headers,
// cut-off records and junk mixed in. Each accepted byte is run through a
// local parser model, and every output transfer is checked field by field
// against the oldest predicted result. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import ips_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_PRINTS = 40;
  localparam logic [23:0] EOF_TAG = 24'h454F46;
  localparam logic [7:0] PATCH_TEXT [0:4] = '{8'h50, 8'h41, 8'h54, 8'h43, 8'h48};
  localparam out_t NO_RESULT = '0;

  typedef struct packed {
    in_t  item;
    logic typed;
    out_t res;
  } row_t;

  // directed patches; typed rows carry the result that must appear
  localparam row_t DIRECTED_ROWS [0:29] = '{
    '{in_t'{8'h50, 1'b0}, 1'b0, NO_RESULT},
    '{in_t'{8'h41, 1'b0}, 1'b0, NO_RESULT},
    '{in_t'{8'h54, 1'b0}, 1'b0, NO_RESULT},
    '{in_t'{8'h43, 1'b0}, 1'b0, NO_RESULT},
    '{in_t'{8'h58, 1'b0}, 1'b1, out_t'{KIND_ERROR, 24'h000000, 16'h0000, 8'h00}},
    '{in_t'{8'h48, 1'b0}, 1'b0, NO_RESULT},
    '{in_t'{8'h50, 1'b1}, 1'b0, NO_RESULT},
    '{in_t'{8'h41, 1'b0}, 1'b0, NO_RESULT},
    '{in_t'{8'h54, 1'b0}, 1'b0, NO_RESULT},
    '{in_t'{8'h43, 1'b0}, 1'b0, NO_RESULT},
    '{in_t'{8'h48, 1'b0}, 1'b0, NO_RESULT},
    '{in_t'{8'hFF, 1'b0}, 1'b0, NO_RESULT},
    '{in_t'{8'hFF, 1'b0}, 1'b0, NO_RESULT},
    '{in_t'{8'hFF, 1'b0}, 1'b0, NO_RESULT},
    '{in_t'{8'h00, 1'b0}, 1'b0, NO_RESULT},
    '{in_t'{8'h02, 1'b0}, 1'b0, NO_RESULT},
    '{in_t'{8'hAB, 1'b0}, 1'b1, out_t'{KIND_WRITE, 24'hFFFFFF, 16'h0000, 8'hAB}},
    '{in_t'{8'h55, 1'b0}, 1'b1, out_t'{KIND_WRITE, 24'h000000, 16'h0000, 8'h55}},
    '{in_t'{8'h00, 1'b0}, 1'b0, NO_RESULT},
    '{in_t'{8'h10, 1'b0}, 1'b0, NO_RESULT},
    '{in_t'{8'h00, 1'b0}, 1'b0, NO_RESULT},
    '{in_t'{8'h00, 1'b0}, 1'b0, NO_RESULT},
    '{in_t'{8'h00, 1'b0}, 1'b0, NO_RESULT},
    '{in_t'{8'h00, 1'b0}, 1'b0, NO_RESULT},
    '{in_t'{8'h00, 1'b0}, 1'b0, NO_RESULT},
    '{in_t'{8'hC3, 1'b0}, 1'b1, out_t'{KIND_FILL, 24'h001000, 16'h0000, 8'hC3}},
    '{in_t'{8'h45, 1'b0}, 1'b0, NO_RESULT},
    '{in_t'{8'h4F, 1'b0}, 1'b0, NO_RESULT},
    '{in_t'{8'h46, 1'b0}, 1'b1, out_t'{KIND_END, 24'h000000, 16'h0000, 8'h00}},
    '{in_t'{8'h00, 1'b0}, 1'b0, NO_RESULT}
  };

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  // parser model state
  phase_e      mdl_phase;
  logic [2:0]  mdl_field_cnt;
  logic [23:0] mdl_rec_offset;
  logic [23:0] mdl_wr_addr;
  logic [15:0] mdl_remaining;
  logic [15:0] mdl_run_len;

  out_t patch_results_q [$];
  row_t offered_q [$];
  in_t  patch_bytes_q [$];

  int err_cnt = 0;
  int parsed_cnt = 0;
  int cycle_cnt = 0;
  int tx_idle_pct = 27;
  int rx_idle_pct = 52;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;

  ips_patch_stream_parser uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  task automatic report(input string what, input logic [23:0] got, input logic [23:0] want);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS) begin
      $display("mismatch %s: got %h want %h", what, got, want);
    end
  endtask

  task automatic model_reset();
    mdl_phase      = PH_HEADER;
    mdl_field_cnt  = '0;
    mdl_rec_offset = '0;
    mdl_wr_addr    = '0;
    mdl_remaining  = '0;
    mdl_run_len    = '0;
  endtask

  task automatic ips_parse_byte(input in_t it, output logic has, output out_t res,
                                output logic ignored);
    logic [7:0] b;
    b = it.in_byte;
    has = 1'b0;
    res = NO_RESULT;
    if (it.start_of_patch) begin
      model_reset();
    end
    ignored = (mdl_phase == PH_DONE) || (mdl_phase == PH_ERROR);
    case (mdl_phase)
      PH_HEADER, PH_HDR_BAD: begin
        if (b != PATCH_TEXT[mdl_field_cnt]) begin
          mdl_phase = PH_HDR_BAD;
        end
        mdl_field_cnt++;
        if (mdl_field_cnt == 3'd5) begin
          mdl_field_cnt = '0;
          if (mdl_phase == PH_HDR_BAD) begin
            mdl_phase = PH_ERROR;
            has = 1'b1;
            res.kind = KIND_ERROR;
          end else begin
            mdl_phase = PH_OFFSET;
          end
        end
      end
      PH_OFFSET: begin
        mdl_rec_offset = {mdl_rec_offset[15:0], b};
        mdl_field_cnt++;
        if (mdl_field_cnt == 3'd3) begin
          mdl_field_cnt = '0;
          if (mdl_rec_offset == EOF_TAG) begin
            mdl_phase = PH_DONE;
            has = 1'b1;
            res.kind = KIND_END;
          end else begin
            mdl_remaining = '0;
            mdl_phase = PH_SIZE;
          end
        end
      end
      PH_SIZE: begin
        mdl_remaining = {mdl_remaining[7:0], b};
        mdl_field_cnt++;
        if (mdl_field_cnt == 3'd2) begin
          mdl_field_cnt = '0;
          if (mdl_remaining == '0) begin
            mdl_run_len = '0;
            mdl_phase = PH_RUN_LEN;
          end else begin
            mdl_wr_addr = mdl_rec_offset;
            mdl_phase = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        has = 1'b1;
        res = out_t'{KIND_WRITE, mdl_wr_addr, 16'h0000, b};
        mdl_wr_addr = mdl_wr_addr + 24'd1;
        mdl_remaining = mdl_remaining - 16'd1;
        if (mdl_remaining == '0) begin
          mdl_rec_offset = '0;
          mdl_phase = PH_OFFSET;
        end
      end
      PH_RUN_LEN: begin
        mdl_run_len = {mdl_run_len[7:0], b};
        mdl_field_cnt++;
        if (mdl_field_cnt == 3'd2) begin
          mdl_field_cnt = '0;
          mdl_phase = PH_RUN_VAL;
        end
      end
      PH_RUN_VAL: begin
        has = 1'b1;
        res = out_t'{KIND_FILL, mdl_rec_offset, mdl_run_len, b};
        mdl_rec_offset = '0;
        mdl_phase = PH_OFFSET;
      end
      default: begin
      end
    endcase
  endtask

  initial model_reset();

  // checks output transfers first, then predicts from the input transfer
  always @(posedge clk_i) begin : monitor
    out_t got;
    out_t want;
    out_t pred;
    row_t tag;
    logic has;
    logic ignored;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = out_data_o;
        if (patch_results_q.size() == 0) begin
          report("result with nothing expected, address", got.address, '0);
        end else begin
          want = patch_results_q.pop_front();
          if (got.kind !== want.kind) report("kind", 24'(got.kind), 24'(want.kind));
          if (got.address !== want.address) report("address", got.address, want.address);
          if (got.fill_length !== want.fill_length) begin
            report("fill_length", 24'(got.fill_length), 24'(want.fill_length));
          end
          if (got.value !== want.value) report("value", 24'(got.value), 24'(want.value));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        ips_parse_byte(in_data_i, has, pred, ignored);
        if (!ignored) parsed_cnt++;
        tag = (offered_q.size() != 0) ? offered_q.pop_front() : '0;
        if (tag.typed) begin
          patch_results_q = {patch_results_q, tag.res};
        end else if (has) begin
          patch_results_q = {patch_results_q, pred};
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off when one is requested
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        out_stall_i <= 1'b1;
      end else if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  task automatic send_item(input row_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    offered_q = {offered_q, r};
    in_valid_i <= 1'b1;
    in_data_i <= r.item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic put(input logic [7:0] b, input logic s);
    patch_bytes_q = {patch_bytes_q, in_t'{b, s}};
  endtask

  task automatic put_offset(input logic [23:0] off);
    put(off[23:16], 1'b0);
    put(off[15:8], 1'b0);
    put(off[7:0], 1'b0);
  endtask

  task automatic build_patch();
    int sel;
    int bad_at;
    int n_rec;
    int pick;
    int tail;
    logic bad;
    logic [7:0] b;
    logic [23:0] off;
    logic [15:0] sz;
    sel = $urandom_range(99);
    if (sel < 5) begin
      repeat ($urandom_range(1, 12)) put(8'($urandom), $urandom_range(9) == 0);
      return;
    end
    bad = (sel < 13);
    bad_at = $urandom_range(4);
    for (int i = 0; i < 5; i++) begin
      b = PATCH_TEXT[i];
      if (bad && i == bad_at) b = b ^ (8'h01 << $urandom_range(7));
      put(b, (i == 0) && ($urandom_range(19) != 0));
    end
    if (bad) begin
      repeat ($urandom_range(0, 3)) put(8'($urandom), 1'b0);
      return;
    end
    n_rec = $urandom_range(1, 4);
    for (int r = 0; r < n_rec; r++) begin
      pick = $urandom_range(9);
      if (pick == 0) off = {16'hFFFF, 8'($urandom_range(240, 255))};
      else if (pick == 1) off = {8'h45, 8'h4F, 8'($urandom)};
      else off = 24'($urandom);
      put_offset(off);
      if ($urandom_range(3) == 0) begin
        pick = $urandom_range(5);
        sz = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom);
        put(8'h00, 1'b0);
        put(8'h00, 1'b0);
        put(sz[15:8], 1'b0);
        put(sz[7:0], 1'b0);
        put(8'($urandom), 1'b0);
      end else begin
        sz = ($urandom_range(9) == 0) ? 16'($urandom_range(13, 48))
                                      : 16'($urandom_range(1, 12));
        put(sz[15:8], 1'b0);
        put(sz[7:0], 1'b0);
        repeat (sz) put(8'($urandom), 1'b0);
      end
    end
    tail = $urandom_range(9);
    if (tail < 8) begin
      put_offset(EOF_TAG);
      repeat ($urandom_range(0, 2)) put(8'($urandom), 1'b0);
    end else if (tail == 8) begin
      // record cut off part way through its data
      put_offset(24'($urandom));
      put(8'($urandom_range(1, 255)), 1'b0);
      put(8'($urandom), 1'b0);
      repeat ($urandom_range(0, 5)) put(8'($urandom), 1'b0);
    end
  endtask

  initial begin
    int targets [0:2];
    int tx_pcts [0:2];
    int rx_pcts [0:2];
    targets = '{350, 670, 990};
    tx_pcts = '{27, 52, 0};
    rx_pcts = '{52, 27, 0};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (DIRECTED_ROWS[i]) send_item(DIRECTED_ROWS[i]);
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = tx_pcts[ph];
      rx_idle_pct = rx_pcts[ph];
      if (ph == 1) hold_reqs <= hold_reqs + 1;
      while (parsed_cnt < targets[ph]) begin
        build_patch();
        while (patch_bytes_q.size() != 0) begin
          send_item('{patch_bytes_q.pop_front(), 1'b0, NO_RESULT});
        end
      end
      // sender pauses until everything outstanding has drained
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while (patch_results_q.size() != 0) @(posedge clk_i);
    end
    repeat (16) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
